/* hdl/ism_pkg.sv */
package ism_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int DEPTH_DEF   = 64;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] item_start;
    logic signed [COORD_WIDTH-1:0] item_stop;
    logic                          item_last;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] merged_start;
    logic signed [COORD_WIDTH-1:0] merged_stop;
    logic                          merged_last;
    logic                          items_dropped;
  } res_item_t;

  // datapath operations issued by the controller, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SORT_INIT,
    OP_RD_CUR,
    OP_LAT_CUR,
    OP_CMP,
    OP_PUT,
    OP_SW_RD0,
    OP_SW_INIT,
    OP_SW_STEP,
    OP_SW_END
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic n_one;        // set holds a single interval
    logic i_next_done;  // current insertion is the final one
    logic j_one;        // hole index has reached one
    logic cur_first;    // held interval orders ahead of the one read back
    logic k_done;       // sweep has read the final entry
  } dp_status_t;

endpackage

/* hdl/ism_ram.sv */
module ism_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/ism_ctrl.sv */
module ism_ctrl import ism_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       item_last_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o,
  output logic       busy_o
);

  typedef enum logic [3:0] {
    S_LOAD,
    S_SORT_INIT,
    S_RD_CUR,
    S_LAT_CUR,
    S_CMP,
    S_PUT,
    S_SW_RD0,
    S_SW_INIT,
    S_SW_STEP,
    S_SW_END
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    case (state_q)
      S_LOAD: begin
        if (start_i) begin
          cmd_o.op = OP_LOAD;
          if (item_last_i) state_d = S_SORT_INIT;
        end
      end
      S_SORT_INIT: begin
        cmd_o.op = OP_SORT_INIT;
        state_d  = status_i.n_one ? S_SW_RD0 : S_RD_CUR;
      end
      S_RD_CUR: begin
        cmd_o.op = OP_RD_CUR;
        state_d  = S_LAT_CUR;
      end
      S_LAT_CUR: begin
        cmd_o.op = OP_LAT_CUR;
        state_d  = S_CMP;
      end
      S_CMP: begin
        cmd_o.op = OP_CMP;
        if (status_i.cur_first) begin
          if (status_i.j_one) state_d = S_PUT;
        end else begin
          state_d = status_i.i_next_done ? S_SW_RD0 : S_RD_CUR;
        end
      end
      S_PUT: begin
        cmd_o.op = OP_PUT;
        state_d  = status_i.i_next_done ? S_SW_RD0 : S_RD_CUR;
      end
      S_SW_RD0: begin
        cmd_o.op = OP_SW_RD0;
        state_d  = S_SW_INIT;
      end
      S_SW_INIT: begin
        cmd_o.op = OP_SW_INIT;
        state_d  = status_i.k_done ? S_LOAD : S_SW_STEP;
      end
      S_SW_STEP: begin
        cmd_o.op = OP_SW_STEP;
        if (status_i.k_done) state_d = S_SW_END;
      end
      S_SW_END: begin
        cmd_o.op = OP_SW_END;
        state_d  = S_LOAD;
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != S_LOAD);
    end
  end

  assign busy_o = busy_q;

endmodule

/* hdl/ism_dp.sv */
module ism_dp import ism_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_cmd_t    cmd_i,
  input  in_item_t   item_i,
  output dp_status_t status_o,
  output logic       res_valid_o,
  output res_item_t  res_o
);

  localparam int CW   = COORD_WIDTH;
  localparam int EW   = 2 * CW;
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [CNTW-1:0] count_q, count_d;
  logic [CNTW-1:0] i_q, i_d;
  logic [CNTW-1:0] j_q, j_d;
  logic [CNTW-1:0] k_q, k_d;
  logic            ovf_q, ovf_d;
  logic [EW-1:0]   cur_q, cur_d;
  logic [CW-1:0]   run_lo_q, run_lo_d;
  logic [CW-1:0]   run_hi_q, run_hi_d;
  logic            out_vld_q, out_vld_d;
  res_item_t       out_q, out_d;

  logic            we;
  logic [CNTW-1:0] waddr, raddr;
  logic [EW-1:0]   wdata, rdata;

  logic [CW-1:0]   rd_start, rd_stop, cur_start, cur_stop;
  logic            cur_first, overlap, extend;
  logic [CNTW-1:0] j_m1, j_m2, i_p1, k_p1;

  // entries are packed {stop, start}
  assign rd_start  = rdata[CW-1:0];
  assign rd_stop   = rdata[EW-1:CW];
  assign cur_start = cur_q[CW-1:0];
  assign cur_stop  = cur_q[EW-1:CW];

  assign cur_first = ($signed(cur_start) < $signed(rd_start)) ||
                     ((cur_start == rd_start) && ($signed(cur_stop) < $signed(rd_stop)));
  assign overlap = $signed(rd_start) <= $signed(run_hi_q);
  assign extend  = $signed(rd_stop) > $signed(run_hi_q);

  assign j_m1 = j_q - CNTW'(1);
  assign j_m2 = j_q - CNTW'(2);
  assign i_p1 = i_q + CNTW'(1);
  assign k_p1 = k_q + CNTW'(1);

  assign status_o.n_one       = (count_q == CNTW'(1));
  assign status_o.i_next_done = (i_p1 == count_q);
  assign status_o.j_one       = (j_q == CNTW'(1));
  assign status_o.cur_first   = cur_first;
  assign status_o.k_done      = (k_q == count_q);

  always_comb begin
    count_d   = count_q;
    i_d       = i_q;
    j_d       = j_q;
    k_d       = k_q;
    ovf_d     = ovf_q;
    cur_d     = cur_q;
    run_lo_d  = run_lo_q;
    run_hi_d  = run_hi_q;
    out_vld_d = 1'b0;
    out_d     = out_q;
    we        = 1'b0;
    waddr     = j_q;
    wdata     = cur_q;
    raddr     = '0;
    case (cmd_i.op)
      OP_LOAD: begin
        if (count_q < CNTW'(DEPTH)) begin
          we      = 1'b1;
          waddr   = count_q;
          wdata   = {item_i.item_stop, item_i.item_start};
          count_d = count_q + CNTW'(1);
        end else begin
          ovf_d = 1'b1;
        end
      end
      OP_SORT_INIT: begin
        i_d = CNTW'(1);
      end
      OP_RD_CUR: begin
        raddr = i_q;
        j_d   = i_q;
      end
      OP_LAT_CUR: begin
        cur_d = rdata;
        raddr = j_m1;
      end
      OP_CMP: begin
        we = 1'b1;
        if (cur_first) begin
          // shift the larger entry up one slot and look further down
          wdata = rdata;
          j_d   = j_m1;
          raddr = j_m2;
        end else begin
          wdata = cur_q;
          i_d   = i_p1;
        end
      end
      OP_PUT: begin
        we  = 1'b1;
        i_d = i_p1;
      end
      OP_SW_RD0: begin
        raddr = '0;
        k_d   = CNTW'(1);
      end
      OP_SW_INIT: begin
        run_lo_d = rd_start;
        run_hi_d = rd_stop;
        if (k_q == count_q) begin
          out_vld_d = 1'b1;
          out_d     = '{merged_start: rd_start, merged_stop: rd_stop,
                        merged_last: 1'b1, items_dropped: ovf_q};
          count_d   = '0;
          ovf_d     = 1'b0;
        end else begin
          raddr = k_q;
          k_d   = k_p1;
        end
      end
      OP_SW_STEP: begin
        if (overlap) begin
          if (extend) run_hi_d = rd_stop;
        end else begin
          out_vld_d = 1'b1;
          out_d     = '{merged_start: run_lo_q, merged_stop: run_hi_q,
                        merged_last: 1'b0, items_dropped: ovf_q};
          run_lo_d  = rd_start;
          run_hi_d  = rd_stop;
        end
        if (k_q != count_q) begin
          raddr = k_q;
          k_d   = k_p1;
        end
      end
      OP_SW_END: begin
        out_vld_d = 1'b1;
        out_d     = '{merged_start: run_lo_q, merged_stop: run_hi_q,
                      merged_last: 1'b1, items_dropped: ovf_q};
        count_d   = '0;
        ovf_d     = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      ovf_q     <= 1'b0;
      i_q       <= '0;
      j_q       <= '0;
      k_q       <= '0;
      out_vld_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      ovf_q     <= ovf_d;
      i_q       <= i_d;
      j_q       <= j_d;
      k_q       <= k_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    run_lo_q <= run_lo_d;
    run_hi_q <= run_hi_d;
    out_q    <= out_d;
  end

  ism_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr[AW-1:0]),
    .wdata_i (wdata),
    .raddr_i (raddr[AW-1:0]),
    .rdata_o (rdata)
  );

  assign res_valid_o = out_vld_q;
  assign res_o       = out_q;

endmodule

/* hdl/interval_sort_merge_core.sv */
// Merges overlapping signed intervals, one set at a time. Loading takes one beat
// per cycle, busy_o low. On the beat with item_last the set of n intervals is sorted
// in the store (one read and one write port): a setup step, a read, a latch and a
// compare per insert, one more compare per shifted entry; then it is swept, busy_o
// high; the final result strobes in the first idle cycle. The receiver cannot stall.
// Reset (rst_ni, async low) empties the set; the store contents are not cleared.
module interval_sort_merge_core import ism_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  input  in_item_t  item_i,
  output logic      res_valid_o,
  output res_item_t res_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // controller: sequences load, sort and sweep phases
  ism_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .item_last_i (item_i.item_last),
    .status_i    (status),
    .cmd_o       (cmd),
    .busy_o      (busy_o)
  );

  // datapath: store, counters, comparators and the result register
  ism_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .item_i      (item_i),
    .status_o    (status),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

`ifndef SYNTHESIS
  // the last beat of a set always starts the sort
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && item_i.item_last) |=> busy_o)
    else $error("last beat did not start processing");

  // only the final merged interval may appear once the block is idle again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.merged_last) |-> busy_o)
    else $error("non-final result outside of a sweep");

  // busy only rises on a last beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i && item_i.item_last))
    else $error("busy rose without a last beat");

  // the final result closes the set: nothing follows directly after it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.merged_last) |=> !res_valid_o)
    else $error("result after the final merged interval");
`endif

endmodule

/* tb/tb_interval_sort_merge_core.sv */
`timescale 1ns / 100ps

module tb_interval_sort_merge_core;
  import ism_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int CYCLE_LIMIT = 400000;
  // quiet time after the last merged interval: longer than any sweep
  localparam int SETTLE      = 3 * DEPTH + 16;
  localparam int RAND_BEATS  = 500;
  localparam int MAX_REPORTS = 40;

  localparam logic signed [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam logic signed [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};

  typedef struct {
    in_item_t    beat;
    int unsigned gap_after;   // idle cycles after this beat is taken
    bit          wait_drain;  // hold this beat until all merges are out
  } send_beat_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      start_i     = 1'b0;
  in_item_t  item_i      = '0;
  logic      busy_o;
  logic      res_valid_o;
  res_item_t res_o;

  // stimulus and expected merges
  send_beat_t intervals_to_send[$];
  res_item_t  merged_due[$];

  // shadow of the block's interval store
  logic signed [COORD_WIDTH-1:0] held_lo[DEPTH];
  logic signed [COORD_WIDTH-1:0] held_hi[DEPTH];
  int unsigned held_cnt  = 0;
  bit          held_lost = 1'b0;

  int unsigned beats_queued   = 0;
  int unsigned beats_taken    = 0;
  int unsigned sets_closed    = 0;
  int unsigned sets_lost      = 0;
  int unsigned merges_checked = 0;
  int unsigned mismatches     = 0;
  int unsigned cycle_cnt      = 0;
  int unsigned idle_left      = 0;

  interval_sort_merge_core #(.DEPTH(DEPTH)) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .item_i      (item_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_REPORTS) begin
      $display("[%0t] MISMATCH: %s", $time, what);
    end
    mismatches++;
  endtask

  // Shadow of one accepted beat. Loads the store; on the closing beat it sorts
  // by start then stop (signed), sweeps, and queues the merged intervals.
  task automatic absorb_interval(input in_item_t beat);
    logic signed [COORD_WIDTH-1:0] cur_lo, cur_hi, run_lo, run_hi;
    res_item_t                     merged;
    int                            i, j;
    if (held_cnt < DEPTH) begin
      held_lo[held_cnt] = beat.item_start;
      held_hi[held_cnt] = beat.item_stop;
      held_cnt++;
    end else begin
      held_lost = 1'b1;   // store full: beat is dropped
    end
    if (!beat.item_last) return;

    for (i = 1; i < held_cnt; i++) begin
      cur_lo = held_lo[i];
      cur_hi = held_hi[i];
      j = i;
      while (j > 0 && (cur_lo < held_lo[j-1] ||
                       (cur_lo == held_lo[j-1] && cur_hi < held_hi[j-1]))) begin
        held_lo[j] = held_lo[j-1];
        held_hi[j] = held_hi[j-1];
        j--;
      end
      held_lo[j] = cur_lo;
      held_hi[j] = cur_hi;
    end

    // touching intervals merge too, hence <=
    run_lo = held_lo[0];
    run_hi = held_hi[0];
    for (i = 1; i < held_cnt; i++) begin
      if (held_lo[i] <= run_hi) begin
        if (held_hi[i] > run_hi) run_hi = held_hi[i];
      end else begin
        merged = '{merged_start: run_lo, merged_stop: run_hi,
                   merged_last: 1'b0, items_dropped: held_lost};
        merged_due = {merged_due, merged};
        run_lo = held_lo[i];
        run_hi = held_hi[i];
      end
    end
    merged = '{merged_start: run_lo, merged_stop: run_hi,
               merged_last: 1'b1, items_dropped: held_lost};
    merged_due = {merged_due, merged};

    sets_closed++;
    if (held_lost) sets_lost++;
    held_cnt  = 0;
    held_lost = 1'b0;
  endtask

  task automatic queue_interval(input logic signed [COORD_WIDTH-1:0] lo,
                                input logic signed [COORD_WIDTH-1:0] hi,
                                input bit last, input int unsigned gap,
                                input bit drain);
    send_beat_t sb;
    sb.beat       = '{item_start: lo, item_stop: hi, item_last: last};
    sb.gap_after  = gap;
    sb.wait_drain = drain;
    intervals_to_send = {intervals_to_send, sb};
    beats_queued++;
  endtask

  function automatic logic signed [COORD_WIDTH-1:0] pick_edge_value();
    case ($urandom_range(0, 5))
      0:       return C_MIN;
      1:       return C_MAX;
      2:       return -1;
      3:       return 0;
      4:       return 1;
      default: return $urandom;
    endcase
  endfunction

  // One set with random content. Most sets cluster near a random base so that
  // overlap, nesting and touching are common; some use wide or edge values.
  task automatic queue_random_set(input int n);
    logic signed [COORD_WIDTH-1:0] base, lo, hi;
    int   flavor;
    bit   burst, drain;
    int unsigned gap;
    base   = $urandom;
    flavor = $urandom_range(0, 9);
    burst  = ($urandom_range(0, 2) == 0);
    drain  = ($urandom_range(0, 7) == 0);
    for (int k = 0; k < n; k++) begin
      if (flavor <= 5) begin
        lo = base + $urandom_range(0, 300);
        if ($urandom_range(0, 7) == 0) hi = lo - $urandom_range(1, 20);   // reversed
        else                           hi = lo + $urandom_range(0, 60);
      end else if (flavor <= 7) begin
        lo = $urandom;
        hi = $urandom;
      end else begin
        lo = pick_edge_value();
        hi = pick_edge_value();
      end
      gap = burst ? 0 : $urandom_range(0, 13);
      queue_interval(lo, hi, k == n - 1, gap, drain && k == 0);
    end
  endtask

  // Driver: a beat goes in at the edge where start_i is high and busy_o low.
  // start_i stays up across back-to-back beats (one assignment per edge).
  always @(posedge clk_i) begin
    send_beat_t nxt;
    if (!rst_ni) begin
      start_i   <= 1'b0;
      idle_left <= 0;
    end else begin
      if (start_i && !busy_o) begin
        absorb_interval(item_i);
        beats_taken++;
      end
      if (!start_i || !busy_o) begin
        if (idle_left > 0) begin
          start_i   <= 1'b0;
          idle_left <= idle_left - 1;
        end else if (intervals_to_send.size() != 0 &&
                     !(intervals_to_send[0].wait_drain && merged_due.size() != 0)) begin
          nxt = intervals_to_send.pop_front();
          item_i    <= nxt.beat;
          start_i   <= 1'b1;
          idle_left <= nxt.gap_after;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobe is one merged interval, checked against the oldest due.
  always @(posedge clk_i) begin
    res_item_t want;
    if (rst_ni && res_valid_o) begin
      if (merged_due.size() == 0) begin
        report_mismatch($sformatf("unexpected merge [%0d, %0d] last=%0b dropped=%0b",
                                  res_o.merged_start, res_o.merged_stop,
                                  res_o.merged_last, res_o.items_dropped));
      end else begin
        want = merged_due.pop_front();
        merges_checked++;
        if (res_o.merged_start !== want.merged_start)
          report_mismatch($sformatf("merged_start got %0d want %0d",
                                    res_o.merged_start, want.merged_start));
        if (res_o.merged_stop !== want.merged_stop)
          report_mismatch($sformatf("merged_stop got %0d want %0d",
                                    res_o.merged_stop, want.merged_stop));
        if (res_o.merged_last !== want.merged_last)
          report_mismatch($sformatf("merged_last got %b want %b",
                                    res_o.merged_last, want.merged_last));
        if (res_o.items_dropped !== want.items_dropped)
          report_mismatch($sformatf("items_dropped got %b want %b",
                                    res_o.items_dropped, want.items_dropped));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout: %0d merges still due, %0d beats unsent",
               merged_due.size(), intervals_to_send.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int set_idx;
    int n;

    // directed sets
    queue_interval(C_MIN, C_MAX, 1, 0, 0);                 // full range
    queue_interval(C_MAX, C_MIN, 1, 0, 0);                 // reversed full range
    queue_interval(C_MIN, C_MIN, 0, 0, 0);                 // two points at the rails
    queue_interval(C_MAX, C_MAX, 1, 2, 0);
    queue_interval(10, 20, 0, 0, 0);                       // touching ends merge
    queue_interval(20, 30, 1, 5, 0);
    queue_interval(50, 60, 0, 1, 1);                       // sender drains first
    queue_interval(-5, 3, 0, 0, 0);                        // unsorted, disjoint
    queue_interval(61, 70, 1, 0, 0);
    queue_interval(7, 9, 0, 0, 0);                         // equal starts
    queue_interval(7, 3, 0, 13, 0);
    queue_interval(7, 12, 1, 0, 0);
    queue_interval(0, 100, 0, 0, 0);                       // nesting and reversed
    queue_interval(20, 30, 0, 0, 0);
    queue_interval(150, 140, 0, 3, 0);
    queue_interval(-10, -20, 1, 0, 0);
    queue_interval(C_MIN, -1, 0, 0, 0);                    // across zero
    queue_interval(0, C_MAX, 0, 7, 0);
    queue_interval(-1, 0, 1, 0, 0);
    queue_interval(32'sh5555_5555, 32'shAAAA_AAAA, 0, 0, 0);
    queue_interval(32'shAAAA_AAAA, 32'sh5555_5555, 1, 0, 0);

    // random sets: mostly small, a few that fill or overflow the store
    set_idx = 0;
    while (beats_queued < RAND_BEATS + 21) begin
      case (set_idx)
        8:       n = DEPTH;
        20:      n = DEPTH + 2;
        32:      n = DEPTH + 1;
        default: n = $urandom_range(1, 12);
      endcase
      queue_random_set(n);
      set_idx++;
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (beats_taken != beats_queued || merged_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    $display("Sent %0d intervals in %0d sets; checked %0d merged intervals.",
             beats_taken, sets_closed, merges_checked);
    $display("%0d sets overflowed the %0d-entry store; %0d mismatches.",
             sets_lost, DEPTH, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/ism_pkg.sv
hdl/ism_ram.sv
hdl/ism_ctrl.sv
hdl/ism_dp.sv
hdl/interval_sort_merge_core.sv
tb/tb_interval_sort_merge_core.sv
